// ----- src/rat_pkg.sv -----
package rat_pkg;

  localparam logic [2:0] CMD_LOAD = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic gcd_start;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic div_done;
    logic apply;
  } rat_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } rat_stat_t;

endpackage

// ----- src/rat_ctrl.sv -----
module rat_ctrl #(
  parameter int WORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  rat_pkg::rat_stat_t  stat_i,
  output rat_pkg::rat_cmd_t   ctl_o
);
  import rat_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_GCD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_o && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;

  logic ov_q, ov_d;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d = ov_q && out_stall_i;
    ctl_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_LOAD: begin
              ctl_o.load = 1'b1;
              state_d = S_OUT;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              ctl_o.mul = 1'b1;
              state_d = S_SUM;
            end
            default: ov_d = 1'b1;
          endcase
        end
      end
      S_SUM: begin
        ctl_o.sum = 1'b1;
        ctl_o.gcd_start = 1'b1;
        state_d = S_GCD;
      end
      S_GCD: begin
        if (stat_i.gcd_done) begin
          ctl_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          ctl_o.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          ctl_o.apply = 1'b1;
          state_d = S_OUT;
        end else begin
          ctl_o.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!(ov_q && out_stall_i)) begin
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

endmodule

// ----- src/rat_dp.sv -----
module rat_dp #(
  parameter int WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] op_num_i,
  input  logic [31:0]        op_den_i,
  input  rat_pkg::rat_cmd_t  ctl_i,
  output rat_pkg::rat_stat_t stat_o,
  input  logic               out_load_i,
  output logic signed [31:0] acc_num_o,
  output logic [31:0]        acc_den_o
);
  import rat_pkg::*;

  localparam int W = WORD_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] num_q, den_q;
  logic [W-1:0] p0_q, p1_q, p2_q;
  logic         sub_q;
  logic [W-1:0] on_w, od_w, non, nod;
  logic         neg_op;
  // binary gcd, one shift or subtract per cycle
  logic [W-1:0] ga_q, gb_q;
  logic [CW-1:0] gk_q;
  logic [W-1:0] rn_q, rd_q;
  logic         rneg_q;
  logic [W-1:0] g_q;
  // restoring divider shared for both quotient words, one bit per cycle
  logic [W-1:0] dq_q, dr_q;
  logic [CW-1:0] cnt_q;
  logic         dsel_q;
  logic [W-1:0] qn_q;
  logic [W:0]   trial;
  logic [W-1:0] gdif;
  logic [W-1:0] sum_v, mag_v;
  logic         gdiv;

  always_comb begin
    on_w = W'($signed(op_num_i));
    od_w = W'(op_den_i);
    non = W'(0) - on_w;
    nod = W'(0) - od_w;
    neg_op = on_w[W-1];
  end

  assign sum_v = sub_q ? (p0_q - p1_q) : (p0_q + p1_q);
  assign mag_v = sum_v[W-1] ? (W'(0) - sum_v) : sum_v;
  assign gdif = (ga_q >= gb_q) ? (ga_q - gb_q) : (gb_q - ga_q);
  assign trial = {dr_q, dq_q[W-1]} - {1'b0, g_q};
  assign gdiv = rd_q != '0 || rn_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
      den_q <= W'(1);
    end else if (ctl_i.load) begin
      num_q <= on_w;
      den_q <= od_w;
    end else if (ctl_i.apply) begin
      if (g_q > W'(1)) begin
        num_q <= rneg_q ? (W'(0) - qn_q) : qn_q;
        den_q <= dq_q;
      end else begin
        num_q <= rneg_q ? (W'(0) - rn_q) : rn_q;
        den_q <= (rn_q == '0) ? W'(1) : rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      sub_q <= cmd_i == CMD_SUB;
      unique case (cmd_i)
        CMD_ADD, CMD_SUB: begin
          p0_q <= W'(od_w * num_q);
          p1_q <= W'(den_q * on_w);
          p2_q <= W'(den_q * od_w);
        end
        CMD_MUL: begin
          p0_q <= W'(num_q * on_w);
          p1_q <= '0;
          p2_q <= W'(den_q * od_w);
        end
        default: begin
          p0_q <= W'(num_q * (neg_op ? nod : od_w));
          p1_q <= '0;
          p2_q <= W'(den_q * (neg_op ? non : on_w));
        end
      endcase
    end
    if (ctl_i.gcd_start) begin
      rn_q <= mag_v;
      rneg_q <= sum_v[W-1];
      rd_q <= p2_q;
      ga_q <= mag_v;
      gb_q <= p2_q;
      gk_q <= '0;
    end else if (ctl_i.gcd_step) begin
      if (ga_q == '0) begin
        ga_q <= gb_q;
        gb_q <= '0;
      end else if (!ga_q[0] && !gb_q[0]) begin
        ga_q <= ga_q >> 1;
        gb_q <= gb_q >> 1;
        gk_q <= gk_q + CW'(1);
      end else if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_q <= gb_q;
        gb_q <= gdif >> 1;
      end else begin
        gb_q <= gdif >> 1;
      end
    end
    if (ctl_i.div_start) begin
      g_q <= ga_q << gk_q;
      dq_q <= rn_q;
      dr_q <= '0;
      cnt_q <= '0;
      dsel_q <= 1'b0;
    end else if (ctl_i.div_step) begin
      if (cnt_q == CW'(W)) begin
        qn_q <= dq_q;
        dq_q <= rd_q;
        dr_q <= '0;
        cnt_q <= '0;
        dsel_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CW'(1);
        if (!trial[W]) begin
          dr_q <= trial[W-1:0];
          dq_q <= {dq_q[W-2:0], 1'b1};
        end else begin
          dr_q <= {dr_q[W-2:0], dq_q[W-1]};
          dq_q <= {dq_q[W-2:0], 1'b0};
        end
      end
    end
    if (out_load_i) begin
      acc_num_o <= 32'($signed(num_q));
      acc_den_o <= 32'(den_q);
    end
  end

  assign stat_o.gcd_done = gb_q == '0;
  assign stat_o.div_done = (dsel_q && cnt_q == CW'(W)) || !gdiv;

endmodule

// ----- src/rational_accumulator_alu.sv -----
// rational accumulator alu
// input channel: in_valid_i / in_stall_o with cmd_i, op_num_i, op_den_i
// output channel: out_valid_o / out_stall_i with acc_num_o, acc_den_o
// one output word per input word, the accumulator after that step
// unused commands answer straight from idle, load through the output state
// arithmetic commands: a multiply step, a sum step, then a binary gcd loop
// of one shift or subtract per cycle, then a shared restoring divider at one
// bit per cycle for both parts (skipped for a zero over zero result)
// only one word is in flight; the next input waits until the result is
// registered at the output
// reset clears the accumulator to 0/1 and drops output valid
// a stalled output word holds its value; input stays stalled meanwhile
module rational_accumulator_alu #(
  parameter int WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] op_num_i,
  input  logic [31:0]        op_den_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] acc_num_o,
  output logic [31:0]        acc_den_o
);
  import rat_pkg::*;

  rat_cmd_t  ctl;
  rat_stat_t stat;
  logic      ov;
  logic      out_load;

  rat_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i,
    .out_valid_o(ov), .out_stall_i, .stat_i(stat), .ctl_o(ctl)
  );

  assign out_valid_o = ov;
  assign out_load = !(ov && out_stall_i);

  rat_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i, .op_num_i, .op_den_i,
    .ctl_i(ctl), .stat_o(stat), .out_load_i(out_load),
    .acc_num_o, .acc_den_o
  );

endmodule

// ----- tb/sv/rational_accumulator_alu_tb.sv -----
module rational_accumulator_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rat_pkg::*;

  localparam logic [2:0] CMD_NOP5 = 3'd5;
  localparam logic [2:0] CMD_NOP6 = 3'd6;
  localparam logic [2:0] CMD_NOP7 = 3'd7;
  localparam logic [31:0] MIN_NEG = 32'h8000_0000;
  localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [31:0] ALL_ONE = 32'hffff_ffff;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] num;
    logic [31:0] den;
    logic        known;
    logic [31:0] exp_num;
    logic [31:0] exp_den;
  } row_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
  } frac_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         cmd_i;
  logic signed [31:0] op_num_i;
  logic [31:0]        op_den_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] acc_num_o;
  logic [31:0]        acc_den_o;

  rational_accumulator_alu u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .cmd_i(cmd_i), .op_num_i(op_num_i), .op_den_i(op_den_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .acc_num_o(acc_num_o), .acc_den_o(acc_den_o)
  );

  frac_t       acc_q[$];
  logic [31:0] model_num;
  logic [31:0] model_den;
  int          errors;
  int          in_idle_pct;
  int          out_idle_pct;
  int          hold_cycles;
  bit          done;

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] gcd32(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic frac_t rational_step(logic [2:0] cmd, logic [31:0] on,
                                          logic [31:0] od);
    logic [31:0] n;
    logic [31:0] d;
    logic [31:0] mag;
    logic [31:0] g;
    logic        neg;
    frac_t       r;
    n = model_num;
    d = model_den;
    case (cmd)
      CMD_LOAD: begin
        n = on;
        d = od;
      end
      CMD_ADD: begin
        n = od * n + d * on;
        d = d * od;
      end
      CMD_SUB: begin
        n = od * n - d * on;
        d = d * od;
      end
      CMD_MUL: begin
        n = n * on;
        d = d * od;
      end
      CMD_DIV: begin
        if (!on[31]) begin
          n = n * od;
          d = d * on;
        end else begin
          n = n * (32'd0 - od);
          d = d * (32'd0 - on);
        end
      end
      default: ;
    endcase
    if (cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV}) begin
      neg = n[31];
      mag = neg ? 32'd0 - n : n;
      g = gcd32(mag, d);
      if (g > 1) begin
        mag = mag / g;
        n = neg ? 32'd0 - mag : mag;
        d = d / g;
      end else if (n == 0) begin
        d = 32'd1;
      end
    end
    model_num = n;
    model_den = d;
    r.num = n;
    r.den = d;
    return r;
  endfunction

  task automatic send_word(logic [2:0] cmd, logic [31:0] on, logic [31:0] od,
                           bit gaps);
    while (gaps && $urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    op_num_i <= on;
    op_den_i <= od;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    acc_q.push_back(rational_step(cmd, on, od));
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom_range(20);
      1: return 32'd0 - $urandom_range(20);
      2: return {$urandom_range(1) ? MIN_NEG : MAX_POS};
      3: return $urandom_range(1000);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    frac_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (acc_q.size() == 0) begin
        $error("acc word with nothing expected");
        errors++;
      end else begin
        e = acc_q.pop_front();
        if (acc_num_o !== e.num) begin
          $error("acc_num expected %h actual %h", e.num, acc_num_o);
          errors++;
        end
        if (acc_den_o !== e.den) begin
          $error("acc_den expected %h actual %h", e.den, acc_den_o);
          errors++;
        end
      end
    end
  end

  row_t rows[$];

  initial begin
    int phase;
    int n;
    logic [2:0] c;
    errors = 0;
    done = 0;
    hold_cycles = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    model_num = 0;
    model_den = 1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    cmd_i = CMD_LOAD;
    op_num_i = 0;
    op_den_i = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      '{CMD_NOP5, 32'd3, 32'd4, 1'b1, 32'd0, 32'd1},
      '{CMD_ADD, 32'd1, 32'd2, 1'b1, 32'd1, 32'd2},
      '{CMD_SUB, 32'd1, 32'd3, 1'b0, 32'd0, 32'd0},
      '{CMD_MUL, 32'd6, 32'd4, 1'b0, 32'd0, 32'd0},
      '{CMD_DIV, ALL_ONE, 32'd7, 1'b0, 32'd0, 32'd0},
      '{CMD_LOAD, MIN_NEG, 32'd0, 1'b1, MIN_NEG, 32'd0},
      '{CMD_NOP7, 32'd1, 32'd1, 1'b1, MIN_NEG, 32'd0},
      '{CMD_MUL, 32'd1, 32'd1, 1'b1, ALL_ONE, 32'd0},
      '{CMD_LOAD, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0},
      '{CMD_ADD, 32'd0, 32'd5, 1'b1, 32'd0, 32'd1},
      '{CMD_LOAD, MAX_POS, ALL_ONE, 1'b1, MAX_POS, ALL_ONE},
      '{CMD_MUL, MAX_POS, ALL_ONE, 1'b0, 32'd0, 32'd0},
      '{CMD_LOAD, 32'd5, 32'd1, 1'b1, 32'd5, 32'd1},
      '{CMD_DIV, MIN_NEG, 32'd3, 1'b0, 32'd0, 32'd0},
      '{CMD_DIV, 32'd0, 32'd1, 1'b0, 32'd0, 32'd0},
      '{CMD_LOAD, 32'd1, 32'd1, 1'b1, 32'd1, 32'd1},
      '{CMD_SUB, MIN_NEG, 32'd1, 1'b0, 32'd0, 32'd0},
      '{CMD_ADD, ALL_ONE, ALL_ONE, 1'b0, 32'd0, 32'd0},
      '{CMD_NOP6, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0}
    };
    foreach (rows[i]) begin
      send_word(rows[i].cmd, rows[i].num, rows[i].den, 1'b0);
      if (rows[i].known && (acc_q[$].num !== rows[i].exp_num
                            || acc_q[$].den !== rows[i].exp_den)) begin
        $error("directed row %0d: table %h/%h predictor %h/%h", i,
               rows[i].exp_num, rows[i].exp_den, acc_q[$].num, acc_q[$].den);
        errors++;
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      in_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 54 : 0;
      out_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 22 : 0;
      if (phase == 2) hold_cycles = 600;
      for (n = 0; n < 310; n++) begin
        if (n % 40 == 0) begin
          send_word(CMD_LOAD, rand_val(), $urandom_range(1, 50), 1'b1);
        end else begin
          c = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(1, 4));
          if ($urandom_range(3) == 0)
            send_word(c, rand_val(), rand_val(), 1'b1);
          else
            send_word(c, 32'd0 - 32'($urandom_range(12)) + 6,
                      $urandom_range(1, 12), 1'b1);
        end
      end
      in_valid_i <= 1'b0;
      while (acc_q.size() != 0) @(posedge clk_i);
    end
    repeat (300) @(posedge clk_i);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- sim.f -----
src/rat_pkg.sv
src/rat_ctrl.sv
src/rat_dp.sv
src/rational_accumulator_alu.sv
tb/sv/rational_accumulator_alu_tb.sv
